/* sv/utf8v_pkg.sv */
// Shared types and constants for the UTF-8 name validator.
`default_nettype none
package utf8v_pkg;

	localparam int unsigned LEN_W    = 16;
	localparam int unsigned COUNT_W  = 17;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned LEAST_W  = 17;

	localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = 16'd1024;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;
	localparam logic [CP_W-1:0]    CP_MAX         = 21'h10FFFF;
	localparam logic [CP_W-1:0]    SURR_LO        = 21'h00D800;
	localparam logic [CP_W-1:0]    SURR_HI        = 21'h00DFFF;
	localparam logic [LEAST_W-1:0] LEAST_2B       = 17'h00080;
	localparam logic [LEAST_W-1:0] LEAST_3B       = 17'h00800;
	localparam logic [LEAST_W-1:0] LEAST_4B       = 17'h10000;
	localparam logic [7:0]         LEAD_2B_LO     = 8'hC2;
	localparam logic [7:0]         LEAD_2B_HI     = 8'hDF;
	localparam logic [7:0]         LEAD_3B_LO     = 8'hE0;
	localparam logic [7:0]         LEAD_3B_HI     = 8'hEF;
	localparam logic [7:0]         LEAD_4B_LO     = 8'hF0;
	localparam logic [7:0]         LEAD_4B_HI     = 8'hF4;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TOO_LONG  = 3'd1,
		ERR_NUL       = 3'd2,
		ERR_BAD_LEAD  = 3'd3,
		ERR_TRUNCATED = 3'd4,
		ERR_BAD_CONT  = 3'd5,
		ERR_RANGE     = 3'd6
	} err_kind_t;

	typedef struct packed {
		logic [1:0]         bytes_left;
		logic [CP_W-1:0]    code_point;
		logic [LEAST_W-1:0] least_allowed;
		logic [COUNT_W-1:0] byte_count;
		err_kind_t          first_error;
	} scan_state_t;

	typedef struct packed {
		logic      emit;
		err_kind_t kind;
	} verdict_t;

endpackage
`default_nettype wire

/* sv/utf8v_ifs.sv */
// Valid/ready channel interfaces for string bytes and verdicts.
`default_nettype none
interface utf8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;
	logic       string_empty;

	modport source (output valid, byte_value, last_byte, string_empty, input ready);
	modport sink   (input valid, byte_value, last_byte, string_empty, output ready);
endinterface

interface utf8v_verdict_if;
	logic       valid;
	logic       ready;
	logic       name_ok;
	logic [2:0] error_kind;

	modport source (output valid, name_ok, error_kind, input ready);
	modport sink   (input valid, name_ok, error_kind, output ready);
endinterface
`default_nettype wire

/* sv/utf8v_step.sv */
// Per-byte decode step: next scan state and end-of-string verdict.
`default_nettype none
module utf8v_step
	import utf8v_pkg::*;
(
	input  wire scan_state_t      cur,
	input  wire logic [7:0]       byte_value,
	input  wire logic             last_byte,
	input  wire logic             string_empty,
	input  wire logic [LEN_W-1:0] max_length,
	output scan_state_t           nxt,
	output verdict_t              verdict
);

	scan_state_t     st;
	logic [CP_W-1:0] cp_new;
	logic            bad_range;

	assign cp_new = {cur.code_point[CP_W-7:0], byte_value[5:0]};
	assign bad_range = (cp_new < {{(CP_W-LEAST_W){1'b0}}, cur.least_allowed}) ||
		(cp_new > CP_MAX) || ((cp_new >= SURR_LO) && (cp_new <= SURR_HI));

	always_comb begin
		st = cur;
		if (!string_empty) begin
			if (cur.byte_count != COUNT_MAX) begin
				st.byte_count = cur.byte_count + 1'b1;
			end
			if (cur.first_error == ERR_NONE) begin
				if (cur.bytes_left != 2'd0) begin
					if (byte_value[7:6] != 2'b10) begin
						st.first_error = ERR_BAD_CONT;
						st.bytes_left  = 2'd0;
					end else begin
						st.code_point = cp_new;
						st.bytes_left = cur.bytes_left - 2'd1;
						if (cur.bytes_left == 2'd1 && bad_range) begin
							st.first_error = ERR_RANGE;
						end
					end
				end else begin
					priority if (byte_value == 8'h00) begin
						st.first_error = ERR_NUL;
					end else if (!byte_value[7]) begin
						// plain ASCII, nothing to track
					end else if (byte_value >= LEAD_2B_LO && byte_value <= LEAD_2B_HI) begin
						st.bytes_left    = 2'd1;
						st.code_point    = {{(CP_W-5){1'b0}}, byte_value[4:0]};
						st.least_allowed = LEAST_2B;
					end else if (byte_value >= LEAD_3B_LO && byte_value <= LEAD_3B_HI) begin
						st.bytes_left    = 2'd2;
						st.code_point    = {{(CP_W-4){1'b0}}, byte_value[3:0]};
						st.least_allowed = LEAST_3B;
					end else if (byte_value >= LEAD_4B_LO && byte_value <= LEAD_4B_HI) begin
						st.bytes_left    = 2'd3;
						st.code_point    = {{(CP_W-3){1'b0}}, byte_value[2:0]};
						st.least_allowed = LEAST_4B;
					end else begin
						st.first_error = ERR_BAD_LEAD;
					end
				end
			end
		end
	end

	always_comb begin
		verdict.emit = string_empty || last_byte;
		priority if (st.byte_count > {1'b0, max_length}) begin
			verdict.kind = ERR_TOO_LONG;
		end else if (st.first_error != ERR_NONE) begin
			verdict.kind = st.first_error;
		end else if (st.bytes_left != 2'd0) begin
			verdict.kind = ERR_TRUNCATED;
		end else begin
			verdict.kind = ERR_NONE;
		end
		// clear for the next string once a verdict is given
		nxt = verdict.emit ? '0 : st;
	end

endmodule
`default_nettype wire

/* sv/utf8_name_validator.sv */
// A verdict is registered in the output register when the byte that ends its string leaves the input register.
// Throughput: one byte per cycle; the input register stalls only when a verdict
// is due and the output register still holds one that has not been taken.
// Reset (arst_n low): scan state and both valid flags clear, max_length returns to 1024.
// The scan state is updated as each byte leaves the input register.
// Top level of the UTF-8 name validator.
`default_nettype none
module utf8_name_validator
	import utf8v_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	utf8v_byte_if.sink            chars,
	utf8v_verdict_if.source       verdict,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata
);

	logic [LEN_W-1:0] max_length_q;
	scan_state_t      state_q;
	scan_state_t      state_nxt;
	verdict_t         vd;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       empty_s1;

	logic       out_valid_q;
	logic       name_ok_q;
	err_kind_t  kind_q;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	utf8v_step u_step (
		.cur          (state_q),
		.byte_value   (byte_s1),
		.last_byte    (last_s1),
		.string_empty (empty_s1),
		.max_length   (max_length_q),
		.nxt          (state_nxt),
		.verdict      (vd)
	);

	// a byte with no verdict never waits on the output side
	assign advance     = valid_s1 && (!vd.emit || !out_valid_q || verdict.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1  <= chars.byte_value;
			last_s1  <= chars.last_byte;
			empty_s1 <= chars.string_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && vd.emit) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vd.emit) begin
			name_ok_q <= (vd.kind == ERR_NONE);
			kind_q    <= vd.kind;
		end
	end

	assign verdict.valid      = out_valid_q;
	assign verdict.name_ok    = name_ok_q;
	assign verdict.error_kind = kind_q;

`ifndef SYNTHESIS
	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		advance && vd.emit |=> state_q.byte_count == '0 && state_q.bytes_left == 2'd0)
		else $error("scan state not cleared after verdict");

	a_no_pending_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.first_error != ERR_NONE |-> state_q.bytes_left == 2'd0)
		else $error("continuations pending after a latched error");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a stalled byte");
`endif

endmodule
`default_nettype wire
